// ===== hdl/ffra_pkg.sv =====
// shared types and constants for the first-fit range allocator
// no dependencies
`timescale 1ns / 1ps

package ffra_pkg;

  localparam int SIZE_W  = 21;
  localparam int ALIGN_W = 4;
  localparam int ADDR_W  = 20;
  localparam int STAT_W  = 3;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOFIT       = 3'd1,
    ST_RANGES_FULL = 3'd2,
    ST_ALLOCS_FULL = 3'd3,
    ST_UNKNOWN     = 3'd4
  } status_t;

endpackage

// ===== hdl/first_fit_range_allocator_core.sv =====
// first-fit range allocator top level: sequencer around a free range ram and an allocation ram
// depends on ffra_pkg and ffra_ram
`timescale 1ns / 1ps
// work per transaction: a scan of the free ranges, a search of the allocation slots (empty
//   slots skip the check state that live ones take) and a shift of range entries
// throughput: one transaction at a time; the next is taken once the result is in the output
//   register; the single read port of each ram sets the pace of every scan and shift
// reset: synchronous active-low rst_n; arena = 2^20; after reset (and after each cfg write)
//   S_INIT writes the first free range before input is taken; allocation slots all empty

module first_fit_range_allocator_core #(
  parameter int MAX_FREE_RANGES = 32,
  parameter int MAX_ALLOCATIONS = 64,
  parameter int OFFSET_BITS     = 20
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [ffra_pkg::SIZE_W-1:0]  cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [ffra_pkg::SIZE_W-1:0]  in_alloc_size,
  input  logic [ffra_pkg::ALIGN_W-1:0] in_align_log2,
  input  logic [ffra_pkg::ADDR_W-1:0]  in_address,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ffra_pkg::STAT_W-1:0]  out_status,
  output logic [ffra_pkg::ADDR_W-1:0]  out_block_address
);

  import ffra_pkg::*;

  // value width: holds offsets up to 2^OFFSET_BITS plus a full request size
  localparam int VW  = (OFFSET_BITS + 1 > SIZE_W) ? OFFSET_BITS + 2 : SIZE_W + 1;
  localparam int CW  = $clog2(MAX_FREE_RANGES + 1);
  localparam int RIW = $clog2(MAX_FREE_RANGES);
  localparam int AIW = (MAX_ALLOCATIONS > 1) ? $clog2(MAX_ALLOCATIONS) : 1;
  localparam int KW  = $clog2(MAX_ALLOCATIONS + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RS_RD, S_RS_CHK, S_AS_RD, S_AS_CHK, S_FS_RD, S_FS_CHK,
    S_FS_END, S_MV_RD, S_MV_WR, S_FIN0, S_FIN1, S_POST, S_DONE
  } state_t;

  state_t state_r;

  logic [SIZE_W-1:0]  arena_r;
  logic [CW-1:0]      count_r, cnt_new_r;
  logic               cmd_r;
  logic [VW-1:0]      size_r, addr_r, b_end_r;
  logic [ALIGN_W-1:0] al_r;
  logic [CW-1:0]      i_r, idx_r, lo_r, hi_r, src_r, dst_r, moves_r;
  logic               lofound_r, left_r, right_r, down_r;
  logic [VW-1:0]      s_r, e_r, b_r, ns_r, ne_r, len_r;
  logic [KW-1:0]      k_r;
  logic [AIW-1:0]     slot_r, freeslot_r;
  logic               freefound_r;
  logic [MAX_ALLOCATIONS-1:0] valid_r;
  logic               fin0_en_r, fin1_en_r;
  logic [CW-1:0]      fin0_idx_r, fin1_idx_r;
  logic [2*VW-1:0]    fin0_dat_r, fin1_dat_r;
  status_t            st_r;
  logic [VW-1:0]      grant_r;
  logic               out_valid_r;
  status_t            out_status_r;
  logic [ADDR_W-1:0]  out_addr_r;

  // ram ports
  logic            rr_we;
  logic [RIW-1:0]  rr_waddr, rr_raddr;
  logic [2*VW-1:0] rr_wdata, rr_rdata;
  logic            ar_we;
  logic [AIW-1:0]  ar_waddr, ar_raddr;
  logic [2*VW-1:0] ar_wdata, ar_rdata;

  ffra_ram #(.WIDTH(2*VW), .DEPTH(MAX_FREE_RANGES)) u_range_ram (
    .clk(clk), .we(rr_we), .waddr(rr_waddr), .wdata(rr_wdata),
    .raddr(rr_raddr), .rdata(rr_rdata)
  );

  ffra_ram #(.WIDTH(2*VW), .DEPTH(MAX_ALLOCATIONS)) u_alloc_ram (
    .clk(clk), .we(ar_we), .waddr(ar_waddr), .wdata(ar_wdata),
    .raddr(ar_raddr), .rdata(ar_rdata)
  );

  // effective arena: saturate at 2^OFFSET_BITS
  logic [VW-1:0] limit, arena_ext, eff;
  assign limit     = VW'(1) << OFFSET_BITS;
  assign arena_ext = VW'(arena_r);
  assign eff       = (arena_ext > limit) ? limit : arena_ext;

  // fit test on the range word coming out of the ram
  logic [VW-1:0] rd_s, rd_e, mask, fit_b, fit_bend;
  logic          fit, fit_left, fit_right;
  assign rd_s      = rr_rdata[2*VW-1:VW];
  assign rd_e      = rr_rdata[VW-1:0];
  assign mask      = (VW'(1) << al_r) - VW'(1);
  assign fit_b     = (rd_s + mask) & ~mask;
  assign fit_bend  = fit_b + size_r;
  assign fit       = (fit_b <= rd_e) && ((rd_e - fit_b) >= size_r) && (fit_b < limit);
  assign fit_left  = fit_b > rd_s;
  assign fit_right = fit_bend < rd_e;

  // allocation slot lookup
  logic [VW-1:0] key, ar_start, ar_len;
  logic          kvalid, kend;
  assign key      = (cmd_r == CMD_ALLOC) ? b_r : addr_r;
  assign ar_start = ar_rdata[2*VW-1:VW];
  assign ar_len   = ar_rdata[VW-1:0];
  assign kvalid   = valid_r[k_r[AIW-1:0]];
  assign kend     = (k_r == KW'(MAX_ALLOCATIONS));

  logic table_full;
  assign table_full = (count_r >= CW'(MAX_FREE_RANGES));

  // ram port drive, one access kind per state
  always_comb begin
    rr_we    = 1'b0;
    rr_waddr = '0;
    rr_wdata = '0;
    rr_raddr = '0;
    ar_we    = 1'b0;
    ar_waddr = slot_r;
    ar_wdata = {b_r, size_r};
    ar_raddr = k_r[AIW-1:0];
    case (state_r)
      S_INIT: begin
        rr_we    = 1'b1;
        rr_wdata = {VW'(0), eff};
      end
      S_RS_RD, S_FS_RD: rr_raddr = i_r[RIW-1:0];
      S_MV_RD:          rr_raddr = src_r[RIW-1:0];
      S_MV_WR: begin
        rr_we    = 1'b1;
        rr_waddr = dst_r[RIW-1:0];
        rr_wdata = rr_rdata;
      end
      S_FIN0: begin
        rr_we    = fin0_en_r;
        rr_waddr = fin0_idx_r[RIW-1:0];
        rr_wdata = fin0_dat_r;
      end
      S_FIN1: begin
        rr_we    = 1'b1;
        rr_waddr = fin1_idx_r[RIW-1:0];
        rr_wdata = fin1_dat_r;
      end
      S_POST: ar_we = (cmd_r == CMD_ALLOC);
      default: ;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      arena_r     <= SIZE_W'(1) << (SIZE_W - 1);
      count_r     <= '0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (cfg_we) begin
      // new arena: drop all allocations and ranges and rebuild the first range
      arena_r <= cfg_wdata;
      valid_r <= '0;
      state_r <= S_INIT;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          count_r <= (eff == '0) ? CW'(0) : CW'(1);
          state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r       <= in_cmd;
            size_r      <= VW'(in_alloc_size);
            al_r        <= in_align_log2;
            addr_r      <= VW'(in_address);
            grant_r     <= '0;
            i_r         <= '0;
            k_r         <= '0;
            freefound_r <= 1'b0;
            state_r     <= (in_cmd == CMD_ALLOC) ? S_RS_RD : S_AS_RD;
          end
        end
        // first-fit scan over the range table
        S_RS_RD: begin
          if (i_r == count_r) begin
            st_r    <= ST_NOFIT;
            state_r <= S_DONE;
          end else begin
            state_r <= S_RS_CHK;
          end
        end
        S_RS_CHK: begin
          if (fit) begin
            s_r     <= rd_s;
            e_r     <= rd_e;
            b_r     <= fit_b;
            idx_r   <= i_r;
            left_r  <= fit_left;
            right_r <= fit_right;
            if ((size_r != '0) && fit_left && fit_right && table_full) begin
              st_r    <= ST_RANGES_FULL;
              state_r <= S_DONE;
            end else begin
              state_r <= S_AS_RD;
            end
          end else begin
            i_r     <= i_r + CW'(1);
            state_r <= S_RS_RD;
          end
        end
        // allocation slot search, empty slots are skipped without a check state
        S_AS_RD: begin
          if (kend) begin
            if (cmd_r == CMD_FREE) begin
              st_r    <= ST_UNKNOWN;
              state_r <= S_DONE;
            end else if (!freefound_r) begin
              st_r    <= ST_ALLOCS_FULL;
              state_r <= S_DONE;
            end else begin
              slot_r  <= freeslot_r;
              state_r <= S_FS_END;
            end
          end else if (kvalid) begin
            state_r <= S_AS_CHK;
          end else begin
            if (!freefound_r) begin
              freefound_r <= 1'b1;
              freeslot_r  <= k_r[AIW-1:0];
            end
            k_r <= k_r + KW'(1);
          end
        end
        S_AS_CHK: begin
          if (ar_start == key) begin
            slot_r  <= k_r[AIW-1:0];
            len_r   <= ar_len;
            b_end_r <= addr_r + ar_len;
            if (cmd_r == CMD_ALLOC) begin
              state_r <= S_FS_END;
            end else if (ar_len == '0) begin
              state_r <= S_POST;
            end else begin
              i_r       <= '0;
              lo_r      <= '0;
              hi_r      <= '0;
              lofound_r <= 1'b0;
              ns_r      <= addr_r;
              ne_r      <= addr_r + ar_len;
              state_r   <= S_FS_RD;
            end
          end else begin
            k_r     <= k_r + KW'(1);
            state_r <= S_AS_RD;
          end
        end
        // free: find the run of ranges touching [addr, b_end]
        S_FS_RD: begin
          if (i_r == count_r) begin
            if (!lofound_r) begin
              lo_r <= count_r;
              hi_r <= count_r;
            end
            state_r <= S_FS_END;
          end else begin
            state_r <= S_FS_CHK;
          end
        end
        S_FS_CHK: begin
          if (!lofound_r && (rd_e < addr_r)) begin
            i_r     <= i_r + CW'(1);
            state_r <= S_FS_RD;
          end else begin
            if (!lofound_r) begin
              lofound_r <= 1'b1;
              lo_r      <= i_r;
              hi_r      <= i_r;
              if (rd_s < addr_r) ns_r <= rd_s;
            end
            if (rd_s <= b_end_r) begin
              hi_r    <= i_r + CW'(1);
              if (rd_e > b_end_r) ne_r <= rd_e;
              i_r     <= i_r + CW'(1);
              state_r <= S_FS_RD;
            end else begin
              state_r <= S_FS_END;
            end
          end
        end
        // plan the table shift and final writes (shared by both commands)
        S_FS_END: begin
          fin0_en_r <= 1'b0;
          fin1_en_r <= 1'b0;
          down_r    <= 1'b0;
          moves_r   <= '0;
          cnt_new_r <= count_r;
          state_r   <= S_MV_RD;
          if (cmd_r == CMD_ALLOC) begin
            if (size_r == '0) begin
              state_r <= S_POST;
            end else if (!left_r && !right_r) begin
              src_r     <= idx_r + CW'(1);
              dst_r     <= idx_r;
              down_r    <= 1'b1;
              moves_r   <= count_r - CW'(1) - idx_r;
              cnt_new_r <= count_r - CW'(1);
            end else if (left_r && right_r) begin
              src_r      <= count_r - CW'(1);
              dst_r      <= count_r;
              moves_r    <= count_r - CW'(1) - idx_r;
              fin0_en_r  <= 1'b1;
              fin0_idx_r <= idx_r;
              fin0_dat_r <= {s_r, b_r};
              fin1_en_r  <= 1'b1;
              fin1_idx_r <= idx_r + CW'(1);
              fin1_dat_r <= {b_r + size_r, e_r};
              cnt_new_r  <= count_r + CW'(1);
            end else begin
              fin0_en_r  <= 1'b1;
              fin0_idx_r <= idx_r;
              fin0_dat_r <= left_r ? {s_r, b_r} : {b_r + size_r, e_r};
            end
          end else if (hi_r == lo_r) begin
            if (table_full) begin
              st_r    <= ST_RANGES_FULL;
              state_r <= S_DONE;
            end else begin
              src_r      <= count_r - CW'(1);
              dst_r      <= count_r;
              moves_r    <= count_r - lo_r;
              fin0_en_r  <= 1'b1;
              fin0_idx_r <= lo_r;
              fin0_dat_r <= {addr_r, b_end_r};
              cnt_new_r  <= count_r + CW'(1);
            end
          end else begin
            src_r      <= hi_r;
            dst_r      <= lo_r + CW'(1);
            down_r     <= 1'b1;
            moves_r    <= count_r - hi_r;
            fin0_en_r  <= 1'b1;
            fin0_idx_r <= lo_r;
            fin0_dat_r <= {ns_r, ne_r};
            cnt_new_r  <= count_r - (hi_r - lo_r) + CW'(1);
          end
        end
        // move range entries one at a time, a read state then a write state for each
        S_MV_RD: begin
          state_r <= (moves_r == '0) ? S_FIN0 : S_MV_WR;
        end
        S_MV_WR: begin
          src_r   <= down_r ? src_r + CW'(1) : src_r - CW'(1);
          dst_r   <= down_r ? dst_r + CW'(1) : dst_r - CW'(1);
          moves_r <= moves_r - CW'(1);
          state_r <= S_MV_RD;
        end
        S_FIN0: begin
          state_r <= fin1_en_r ? S_FIN1 : S_POST;
        end
        S_FIN1: begin
          state_r <= S_POST;
        end
        S_POST: begin
          count_r         <= (cmd_r == CMD_ALLOC && size_r == '0) ? count_r :
                             ((cmd_r == CMD_FREE && len_r == '0) ? count_r : cnt_new_r);
          valid_r[slot_r] <= (cmd_r == CMD_ALLOC);
          grant_r         <= (cmd_r == CMD_ALLOC) ? b_r : '0;
          st_r            <= ST_OK;
          state_r         <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_addr_r   <= (st_r == ST_OK) ? grant_r[ADDR_W-1:0] : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_INIT;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_FREE_RANGES))
    else $error("free range count above table size");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!rr_we && !ar_we))
    else $error("ram write while idle");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !cfg_we) |=> !in_ready)
    else $error("second transaction taken while busy");

  a_err_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_block_address == '0))
    else $error("failed transaction carries an address");
`endif

endmodule

// ===== hdl/ffra_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ffra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for first_fit_range_allocator_core: directed table then random traffic
// depends on ffra_pkg and the allocator rtl; the bench carries its own free/alloc table model
`timescale 1ns / 1ps

module testbench;
  import ffra_pkg::*;

  localparam int NRANGES = 32;
  localparam int NSLOTS = 64;
  localparam longint unsigned ARENA_LIMIT = 64'd1 << 20;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int QUIET_TAIL = 200;

  typedef struct {
    logic              cmd;
    logic [SIZE_W-1:0] size;
    logic [ALIGN_W-1:0] align;
    logic [ADDR_W-1:0] addr;
    bit                fixed;
    status_t           st;
    logic [ADDR_W-1:0] grant;
  } txn_t;

  typedef struct {
    status_t           st;
    logic [ADDR_W-1:0] grant;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  logic in_valid, in_ready, in_cmd;
  logic [SIZE_W-1:0] in_alloc_size;
  logic [ALIGN_W-1:0] in_align_log2;
  logic [ADDR_W-1:0] in_address;
  logic out_valid, out_ready;
  logic [STAT_W-1:0] out_status;
  logic [ADDR_W-1:0] out_block_address;

  // model of the block's tables
  logic [SIZE_W:0]   free_lo [NRANGES];
  logic [SIZE_W:0]   free_hi [NRANGES];
  int unsigned       free_cnt;
  logic [ADDR_W-1:0] slot_start [NSLOTS];
  logic [SIZE_W-1:0] slot_len [NSLOTS];
  bit                slot_live [NSLOTS];
  longint unsigned   arena_bytes;

  outcome_t pending_results[$];
  bit       failed = 1'b0;
  bit       quiet = 1'b0;
  bit       cur_fixed = 1'b0;
  outcome_t cur_typed;
  int       out_stall = 0;
  int unsigned cycles = 0;

  first_fit_range_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_alloc_size(in_alloc_size), .in_align_log2(in_align_log2), .in_address(in_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_block_address(out_block_address)
  );

  always #4 clk = ~clk;

  // any write of the arena length starts over with one free range (none for a zero arena) and no allocations
  function automatic void arena_init(input logic [SIZE_W-1:0] value);
    arena_bytes = (value > ARENA_LIMIT) ? ARENA_LIMIT : value;
    for (int i = 0; i < NRANGES; i++) begin
      free_lo[i] = '0;
      free_hi[i] = '0;
    end
    for (int k = 0; k < NSLOTS; k++) begin
      slot_start[k] = '0;
      slot_len[k] = '0;
      slot_live[k] = 1'b0;
    end
    free_hi[0] = (SIZE_W+1)'(arena_bytes);
    free_cnt = (arena_bytes == 0) ? 0 : 1;
  endfunction

  function automatic status_t carve_block(input logic [SIZE_W-1:0] size,
                                          input logic [ALIGN_W-1:0] align,
                                          output logic [ADDR_W-1:0] grant);
    longint unsigned mask, s, e, b;
    int idx, slot, spare;
    bit found, lgap, rgap;
    mask = (64'd1 << align) - 1;
    found = 1'b0;
    idx = 0;
    s = 0; e = 0; b = 0;
    slot = -1;
    spare = -1;
    lgap = 1'b0;
    rgap = 1'b0;
    grant = '0;
    for (int i = 0; i < free_cnt; i++) begin
      s = free_lo[i];
      e = free_hi[i];
      b = (s + mask) & ~mask;
      if (b <= e && e - b >= size && b < ARENA_LIMIT) begin
        found = 1'b1;
        idx = i;
        break;
      end
    end
    if (!found) return ST_NOFIT;
    if (size != 0) begin
      lgap = b > s;
      rgap = b + size < e;
      if (lgap && rgap && free_cnt >= NRANGES) return ST_RANGES_FULL;
    end
    for (int k = 0; k < NSLOTS; k++) begin
      if (slot_live[k]) begin
        if (slot_start[k] == b) begin
          slot = k;
          break;
        end
      end else if (spare < 0) begin
        spare = k;
      end
    end
    if (slot < 0) slot = spare;
    if (slot < 0) return ST_ALLOCS_FULL;
    if (size != 0) begin
      if (!lgap && !rgap) begin
        for (int k = idx; k + 1 < free_cnt; k++) begin
          free_lo[k] = free_lo[k+1];
          free_hi[k] = free_hi[k+1];
        end
        free_cnt--;
      end else if (lgap && rgap) begin
        for (int k = free_cnt; k > idx + 1; k--) begin
          free_lo[k] = free_lo[k-1];
          free_hi[k] = free_hi[k-1];
        end
        free_hi[idx] = (SIZE_W+1)'(b);
        free_lo[idx+1] = (SIZE_W+1)'(b + size);
        free_hi[idx+1] = (SIZE_W+1)'(e);
        free_cnt++;
      end else if (lgap) begin
        free_hi[idx] = (SIZE_W+1)'(b);
      end else begin
        free_lo[idx] = (SIZE_W+1)'(b + size);
      end
    end
    slot_start[slot] = ADDR_W'(b);
    slot_len[slot] = size;
    slot_live[slot] = 1'b1;
    grant = ADDR_W'(b);
    return ST_OK;
  endfunction

  function automatic status_t return_block(input logic [ADDR_W-1:0] addr);
    int slot, lo, hi, merged;
    longint unsigned a, b, ns, ne;
    slot = -1;
    for (int k = 0; k < NSLOTS; k++) begin
      if (slot_live[k] && slot_start[k] == addr) begin
        slot = k;
        break;
      end
    end
    if (slot < 0) return ST_UNKNOWN;
    a = addr;
    b = a + slot_len[slot];
    if (b == a) begin
      slot_live[slot] = 1'b0;
      return ST_OK;
    end
    lo = 0;
    while (lo < free_cnt && free_hi[lo] < a) lo++;
    hi = lo;
    while (hi < free_cnt && free_lo[hi] <= b) hi++;
    merged = hi - lo;
    if (merged == 0 && free_cnt >= NRANGES) return ST_RANGES_FULL;
    ns = a;
    ne = b;
    if (merged > 0) begin
      if (free_lo[lo] < ns) ns = free_lo[lo];
      if (free_hi[hi-1] > ne) ne = free_hi[hi-1];
    end
    if (merged == 0) begin
      for (int k = free_cnt; k > lo; k--) begin
        free_lo[k] = free_lo[k-1];
        free_hi[k] = free_hi[k-1];
      end
    end else begin
      for (int k = 0; hi + k < free_cnt; k++) begin
        free_lo[lo+1+k] = free_lo[hi+k];
        free_hi[lo+1+k] = free_hi[hi+k];
      end
    end
    free_lo[lo] = (SIZE_W+1)'(ns);
    free_hi[lo] = (SIZE_W+1)'(ne);
    free_cnt = free_cnt - merged + 1;
    slot_live[slot] = 1'b0;
    return ST_OK;
  endfunction

  // model update on every accepted request, check on every accepted response
  always @(posedge clk) begin
    outcome_t want, got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (in_cmd == CMD_ALLOC) begin
          want.st = carve_block(in_alloc_size, in_align_log2, want.grant);
        end else begin
          want.st = return_block(in_address);
          want.grant = '0;
        end
        if (want.st != ST_OK) want.grant = '0;
        // hand-typed rows take their own expectation
        if (cur_fixed) want = cur_typed;
        pending_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("response with no request outstanding: status %0d address %0h",
                 out_status, out_block_address);
          failed = 1'b1;
        end else begin
          got = pending_results.pop_front();
          if (out_status !== got.st) begin
            $error("status: expected %0d actual %0d", got.st, out_status);
            failed = 1'b1;
          end
          if (out_block_address !== got.grant) begin
            $error("block_address: expected %0h actual %0h", got.grant, out_block_address);
            failed = 1'b1;
          end
        end
      end
    end
  end

  // response back-pressure in random bursts, none during the quiet tail
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (out_stall > 0) begin
      out_stall = out_stall - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // present one request and hold it until the handshake; called right after a rising edge
  task automatic send(input txn_t t);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= t.cmd;
    in_alloc_size <= t.size;
    in_align_log2 <= t.align;
    in_address <= t.addr;
    cur_fixed <= t.fixed;
    cur_typed.st <= t.st;
    cur_typed.grant <= t.grant;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // idle the input, drain all responses, let any tail work finish, then rewrite the arena
  task automatic set_arena(input logic [SIZE_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    arena_init(value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic txn_t random_txn(input int alloc_pct);
    txn_t t;
    int k;
    t.fixed = 1'b0;
    t.st = ST_OK;
    t.grant = '0;
    t.cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
    t.align = ($urandom_range(0, 3) == 0) ? ALIGN_W'($urandom_range(0, 15)) :
                                            ALIGN_W'($urandom_range(0, 4));
    case ($urandom_range(0, 19))
      0: t.size = SIZE_W'($urandom);
      1: t.size = SIZE_W'($urandom_range(0, arena_bytes + 2));
      2: t.size = 0;
      default: t.size = SIZE_W'($urandom_range(1, arena_bytes / 64 + 4));
    endcase
    t.addr = ADDR_W'($urandom);
    // most frees target a live block so the table actually drains and coalesces
    if ($urandom_range(0, 9) < 8) begin
      k = $urandom_range(0, NSLOTS - 1);
      for (int n = 0; n < NSLOTS; n++) begin
        if (slot_live[(k + n) % NSLOTS]) begin
          t.addr = slot_start[(k + n) % NSLOTS];
          break;
        end
      end
    end
    return t;
  endfunction

  // directed rows: typed expectation only where it is obvious, the rest go to the model
  txn_t directed[] = '{
    // whole arena in one piece, then nothing left
    '{CMD_ALLOC, 21'h100000, 4'd0, 20'h0, 1'b1, ST_OK, 20'h0},
    '{CMD_ALLOC, 21'd1, 4'd0, 20'h0, 1'b1, ST_NOFIT, 20'h0},
    '{CMD_FREE, 21'd0, 4'd0, 20'h0, 1'b1, ST_OK, 20'h0},
    // double free, then a free of an address never allocated
    '{CMD_FREE, 21'd0, 4'd0, 20'h0, 1'b1, ST_UNKNOWN, 20'h0},
    '{CMD_FREE, 21'd0, 4'd0, 20'hFFFFF, 1'b1, ST_UNKNOWN, 20'h0},
    // zero-size block, then the same start recorded again with a real length
    '{CMD_ALLOC, 21'd0, 4'd0, 20'h0, 1'b1, ST_OK, 20'h0},
    '{CMD_ALLOC, 21'd16, 4'd0, 20'h0, 1'b1, ST_OK, 20'h0},
    '{CMD_FREE, 21'd0, 4'd0, 20'h0, 1'b1, ST_OK, 20'h0},
    '{CMD_ALLOC, 21'h1FFFFF, 4'd0, 20'h0, 1'b1, ST_NOFIT, 20'h0},
    '{CMD_ALLOC, 21'h100001, 4'd0, 20'h0, 1'b1, ST_NOFIT, 20'h0},
    '{CMD_ALLOC, 21'd1, 4'd15, 20'h0, 1'b1, ST_OK, 20'h0},
    // split with gaps on both sides, then frees that coalesce
    '{CMD_ALLOC, 21'd1, 4'd4, 20'h0, 1'b0, ST_OK, 20'h0},
    '{CMD_ALLOC, 21'd100, 4'd12, 20'h0, 1'b0, ST_OK, 20'h0},
    '{CMD_ALLOC, 21'd0, 4'd12, 20'h0, 1'b0, ST_OK, 20'h0},
    '{CMD_FREE, 21'd0, 4'd0, 20'h10, 1'b0, ST_OK, 20'h0},
    '{CMD_FREE, 21'd0, 4'd0, 20'h1000, 1'b0, ST_OK, 20'h0},
    '{CMD_FREE, 21'd0, 4'd0, 20'h0, 1'b0, ST_OK, 20'h0},
    '{CMD_FREE, 21'd0, 4'd0, 20'h1000, 1'b0, ST_OK, 20'h0},
    '{CMD_ALLOC, 21'hFFFFF, 4'd1, 20'h0, 1'b0, ST_OK, 20'h0},
    '{CMD_FREE, 21'd0, 4'd0, 20'h55555, 1'b0, ST_OK, 20'h0}
  };

  // arena settings per random phase and the transactions issued under each
  logic [SIZE_W-1:0] phase_arena[6] = '{21'd4096, 21'd0, 21'd1, 21'h1FFFFF, 21'd600, 21'h100000};
  int phase_len[6] = '{400, 40, 60, 400, 400, 400};

  initial begin
    int total, issued;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_cmd = CMD_ALLOC;
    in_alloc_size = '0;
    in_align_log2 = '0;
    in_address = '0;
    out_ready = 1'b0;
    arena_init(21'h100000);
    total = 0;
    issued = 0;
    foreach (phase_len[p]) total += phase_len[p];
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send(directed[i]);

    foreach (phase_arena[p]) begin
      set_arena(phase_arena[p]);
      for (int n = 0; n < phase_len[p]; n++) begin
        // fill-heavy first half of each phase, drain-heavy second half
        send(random_txn(n < phase_len[p] / 2 ? 80 : 35));
        issued++;
        if (issued >= total - QUIET_TAIL) quiet = 1'b1;
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (!failed) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
